/* src/wrn_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the wake-up radio node controller.
// No dependencies; every other file in the block imports this package.

package wrn_pkg;

  // Field widths of the item, result and configuration beats.
  localparam int unsigned NodeIdW    = 10;
  localparam int unsigned AirtimeW   = 16;
  localparam int unsigned BackoffW   = 20;
  localparam int unsigned WakeupW    = 8;
  localparam int unsigned TimeoutW   = 16;
  localparam int unsigned StateW     = 3;
  localparam int unsigned CfgIndexW  = 3;
  localparam int unsigned CfgDataW   = 20;

  // Item operation codes.
  localparam logic OP_WAKEUP = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  // Mode codes, also reported as state_code.
  localparam logic [StateW-1:0] MODE_SLEEP    = 3'd0;
  localparam logic [StateW-1:0] MODE_RECEIVE  = 3'd1;
  localparam logic [StateW-1:0] MODE_TRANSMIT = 3'd2;
  localparam logic [StateW-1:0] MODE_LISTEN   = 3'd3;
  localparam logic [StateW-1:0] MODE_SEND_WU  = 3'd4;
  localparam logic [StateW-1:0] MODE_RECV_WU  = 3'd5;

  // Configuration register indexes.
  localparam logic [CfgIndexW-1:0] CFG_NODE_ID         = 3'd0;
  localparam logic [CfgIndexW-1:0] CFG_MULTI_HOP       = 3'd1;
  localparam logic [CfgIndexW-1:0] CFG_AIRTIME_TICKS   = 3'd2;
  localparam logic [CfgIndexW-1:0] CFG_BACKOFF_TICKS   = 3'd3;
  localparam logic [CfgIndexW-1:0] CFG_WAKEUP_DELAY    = 3'd4;
  localparam logic [CfgIndexW-1:0] CFG_RECEIVE_TIMEOUT = 3'd5;

  // Reset values of the configuration registers.
  localparam logic [AirtimeW-1:0] AIRTIME_RST = 16'd1;
  localparam logic [WakeupW-1:0]  WAKEUP_RST  = 8'd8;
  localparam logic [TimeoutW-1:0] TIMEOUT_RST = 16'd1000;

  // Configuration register contents.
  typedef struct packed {
    logic [NodeIdW-1:0]  node_id;
    logic                multi_hop;
    logic [AirtimeW-1:0] airtime_ticks;
    logic [BackoffW-1:0] backoff_ticks;
    logic [WakeupW-1:0]  wakeup_delay;
    logic [TimeoutW-1:0] receive_timeout;
  } wrn_cfg_t;

  // One input item as held in the input register.
  typedef struct packed {
    logic               operation;
    logic [NodeIdW-1:0] wakeup_dst;
    logic               gen_hit;
    logic               packet_in_buffer;
  } wrn_item_t;

endpackage

/* src/wrn_in_if.sv */
`timescale 1ns / 1ps
// Input item channel: valid/ready handshake with the item fields.
// Depends on wrn_pkg for field widths.

interface wrn_in_if;
  import wrn_pkg::*;

  logic               valid;
  logic               ready;
  logic               operation;
  logic [NodeIdW-1:0] wakeup_dst;
  logic               gen_hit;
  logic               packet_in_buffer;

  modport source (output valid, output operation, output wakeup_dst,
                  output gen_hit, output packet_in_buffer, input ready);
  modport sink (input valid, input operation, input wakeup_dst,
                input gen_hit, input packet_in_buffer, output ready);
endinterface

/* src/wrn_out_if.sv */
`timescale 1ns / 1ps
// Result channel: valid/ready handshake with state_code and make_packet.
// Depends on wrn_pkg for field widths.

interface wrn_out_if;
  import wrn_pkg::*;

  logic              valid;
  logic              ready;
  logic [StateW-1:0] state_code;
  logic              make_packet;

  modport source (output valid, output state_code, output make_packet, input ready);
  modport sink (input valid, input state_code, input make_packet, output ready);
endinterface

/* src/wrn_cfg_if.sv */
`timescale 1ns / 1ps
// Configuration write channel: valid/ready with register index and data.
// Depends on wrn_pkg for field widths.

interface wrn_cfg_if;
  import wrn_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CfgIndexW-1:0] index;
  logic [CfgDataW-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* src/wrn_cfg_regs.sv */
`timescale 1ns / 1ps
// Configuration register file of the wake-up radio node controller.
// Depends on wrn_pkg; fed by the top level's configuration channel.

module wrn_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          wr_en_i,
  input  logic [wrn_pkg::CfgIndexW-1:0] wr_index_i,
  input  logic [wrn_pkg::CfgDataW-1:0]  wr_data_i,
  output wrn_pkg::wrn_cfg_t             cfg_o
);
  import wrn_pkg::*;

  wrn_cfg_t cfg_q;
  wrn_cfg_t cfg_d;

  // Decode the register index; writes beyond the list are dropped.
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      unique case (wr_index_i)
        CFG_NODE_ID:         cfg_d.node_id         = wr_data_i[NodeIdW-1:0];
        CFG_MULTI_HOP:       cfg_d.multi_hop       = wr_data_i[0];
        CFG_AIRTIME_TICKS:   cfg_d.airtime_ticks   = wr_data_i[AirtimeW-1:0];
        CFG_BACKOFF_TICKS:   cfg_d.backoff_ticks   = wr_data_i[BackoffW-1:0];
        CFG_WAKEUP_DELAY:    cfg_d.wakeup_delay    = wr_data_i[WakeupW-1:0];
        CFG_RECEIVE_TIMEOUT: cfg_d.receive_timeout = wr_data_i[TimeoutW-1:0];
        default:             cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.node_id         <= '0;
      cfg_q.multi_hop       <= 1'b0;
      cfg_q.airtime_ticks   <= AIRTIME_RST;
      cfg_q.backoff_ticks   <= '0;
      cfg_q.wakeup_delay    <= WAKEUP_RST;
      cfg_q.receive_timeout <= TIMEOUT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* src/wrn_mode_ctrl.sv */
`timescale 1ns / 1ps
// Mode state machine, down-counters and result register of the controller.
// Depends on wrn_pkg; takes items from the top level's input register.

module wrn_mode_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  wrn_pkg::wrn_cfg_t          cfg_i,
  input  logic                       item_valid_i,
  input  wrn_pkg::wrn_item_t         item_i,
  output logic                       item_take_o,
  output logic                       res_valid_o,
  input  logic                       res_ready_i,
  output logic [wrn_pkg::StateW-1:0] res_state_code_o,
  output logic                       res_make_packet_o
);
  import wrn_pkg::*;

  logic [StateW-1:0]   mode_q, mode_d;
  logic                flag_q, flag_d;
  logic [BackoffW-1:0] backoff_q, backoff_d;
  logic [AirtimeW-1:0] airtime_q, airtime_d;
  logic [WakeupW-1:0]  wakeup_q, wakeup_d;
  logic [TimeoutW-1:0] timeout_q, timeout_d;
  logic                made;

  logic                res_valid_q, res_valid_d;
  logic [StateW-1:0]   res_state_q;
  logic                res_made_q;

  logic is_tick;
  logic take;

  assign is_tick = (item_i.operation == OP_TICK);

  // A wake-up beat never produces a result, so it always moves on; a tick
  // needs the result register free or being emptied this cycle.
  assign take = item_valid_i && (!is_tick || !res_valid_q || res_ready_i);
  assign item_take_o = take;

  // Next-state logic for one item.
  always_comb begin
    mode_d    = mode_q;
    flag_d    = flag_q;
    backoff_d = backoff_q;
    airtime_d = airtime_q;
    wakeup_d  = wakeup_q;
    timeout_d = timeout_q;
    made      = 1'b0;

    if (take && !is_tick) begin
      if (item_i.wakeup_dst == cfg_i.node_id) begin
        flag_d = 1'b1;
      end
    end else if (take) begin
      unique case (mode_q)
        MODE_SLEEP: begin
          if (flag_q) begin
            wakeup_d = cfg_i.wakeup_delay;
            mode_d   = MODE_RECV_WU;
          end else if (backoff_q == '0) begin
            if (item_i.gen_hit) begin
              made = 1'b1;
              if (cfg_i.multi_hop) begin
                wakeup_d = cfg_i.wakeup_delay;
                mode_d   = MODE_SEND_WU;
              end else begin
                airtime_d = cfg_i.airtime_ticks;
                backoff_d = cfg_i.backoff_ticks;
                mode_d    = MODE_TRANSMIT;
              end
            end
          end else begin
            backoff_d = backoff_q - 1'b1;
          end
        end
        MODE_RECEIVE: begin
          if (item_i.packet_in_buffer) begin
            timeout_d = '0;
            if (cfg_i.multi_hop) begin
              wakeup_d = cfg_i.wakeup_delay;
              mode_d   = MODE_SEND_WU;
            end else begin
              airtime_d = cfg_i.airtime_ticks;
              backoff_d = cfg_i.backoff_ticks;
              mode_d    = MODE_TRANSMIT;
            end
          end else if (timeout_q <= TimeoutW'(1)) begin
            mode_d = MODE_SLEEP;
          end else begin
            timeout_d = timeout_q - 1'b1;
          end
        end
        MODE_TRANSMIT: begin
          if (airtime_q > AirtimeW'(1)) begin
            airtime_d = airtime_q - 1'b1;
          end else begin
            mode_d = MODE_SLEEP;
          end
        end
        MODE_SEND_WU: begin
          if (wakeup_q > WakeupW'(1)) begin
            wakeup_d = wakeup_q - 1'b1;
          end else begin
            airtime_d = cfg_i.airtime_ticks;
            backoff_d = cfg_i.backoff_ticks;
            mode_d    = MODE_TRANSMIT;
          end
        end
        MODE_RECV_WU: begin
          if (wakeup_q <= WakeupW'(1)) begin
            mode_d    = MODE_RECEIVE;
            flag_d    = 1'b0;
            timeout_d = cfg_i.receive_timeout;
          end else begin
            wakeup_d = wakeup_q - 1'b1;
          end
        end
        // Listen and the unused codes hold.
        default: mode_d = mode_q;
      endcase
    end
  end

  // Result register handshake.
  always_comb begin
    res_valid_d = res_valid_q;
    if (take && is_tick) begin
      res_valid_d = 1'b1;
    end else if (res_ready_i) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_SLEEP;
      flag_q      <= 1'b0;
      backoff_q   <= '0;
      airtime_q   <= '0;
      wakeup_q    <= '0;
      timeout_q   <= '0;
      res_valid_q <= 1'b0;
    end else begin
      mode_q      <= mode_d;
      flag_q      <= flag_d;
      backoff_q   <= backoff_d;
      airtime_q   <= airtime_d;
      wakeup_q    <= wakeup_d;
      timeout_q   <= timeout_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Result payload, loaded with the mode after the tick.
  always_ff @(posedge clk_i) begin
    if (take && is_tick) begin
      res_state_q <= mode_d;
      res_made_q  <= made;
    end
  end

  assign res_valid_o       = res_valid_q;
  assign res_state_code_o  = res_state_q;
  assign res_make_packet_o = res_made_q;

endmodule

/* src/wakeup_radio_node_controller.sv */
`timescale 1ns / 1ps
// Top level of the wake-up radio node mode controller.
// Depends on wrn_pkg, the three channel interfaces, wrn_cfg_regs and wrn_mode_ctrl.
//
// Usage:
//   in_i carries items: operation 0 is a wake-up signal seen on air (wakeup_dst
//   is compared with node_id and latches a flag), operation 1 is one time tick
//   that advances the mode and its down-counters.
//   out_o carries one result beat per tick: the mode after the tick and a
//   make_packet pulse. Wake-up beats produce no result.
//   cfg_i writes the six configuration registers by index; it is always
//   ready, and writes are expected only while the block is idle.
// Path: a tick accepted into the input register goes through the mode logic
//   into the result register once that register is free or being emptied,
//   so its result is registered. A wake-up beat takes effect as it leaves
//   the input register, which it may always do.
// Throughput: one item per cycle unless out_o stalls; the one mode stage sets it.
// Reset: mode returns to sleep, all counters and the wake-up flag clear, and
//   the registers take their defaults. Both pipeline registers empty.
// Stall: while out_o is held, the result register keeps its beat, one more
//   tick waits in the input register, and in_i drops ready after that.
//   Wake-up beats still pass the input register, since they give no result.

module wakeup_radio_node_controller (
  input  logic clk_i,
  input  logic rst_ni,
  wrn_in_if.sink    in_i,
  wrn_out_if.source out_o,
  wrn_cfg_if.sink   cfg_i
);
  import wrn_pkg::*;

  wrn_cfg_t  cfg;
  logic      in_valid_q, in_valid_d;
  wrn_item_t in_item_q;
  logic      item_take;
  logic      in_accept;

  assign cfg_i.ready = 1'b1;

  wrn_cfg_regs u_cfg_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_i.valid),
    .wr_index_i (cfg_i.index),
    .wr_data_i  (cfg_i.data),
    .cfg_o      (cfg)
  );

  // Input register: free when empty or when its beat moves on this cycle.
  assign in_i.ready = !in_valid_q || item_take;
  assign in_accept  = in_i.valid && in_i.ready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_accept) begin
      in_valid_d = 1'b1;
    end else if (item_take) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_item_q.operation        <= in_i.operation;
      in_item_q.wakeup_dst       <= in_i.wakeup_dst;
      in_item_q.gen_hit          <= in_i.gen_hit;
      in_item_q.packet_in_buffer <= in_i.packet_in_buffer;
    end
  end

  wrn_mode_ctrl u_mode_ctrl (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg),
    .item_valid_i      (in_valid_q),
    .item_i            (in_item_q),
    .item_take_o       (item_take),
    .res_valid_o       (out_o.valid),
    .res_ready_i       (out_o.ready),
    .res_state_code_o  (out_o.state_code),
    .res_make_packet_o (out_o.make_packet)
  );

endmodule

/* verif/tb_wakeup_radio_node_controller.sv */
`timescale 1ns / 1ps
// Self-checking testbench for wakeup_radio_node_controller: a directed table, then random phases.
// Depends on wrn_pkg, the wrn_in_if, wrn_out_if and wrn_cfg_if interfaces, and the block's RTL.

module tb_wakeup_radio_node_controller;
  import wrn_pkg::*;

  // One state report as it leaves the block.
  typedef struct packed {
    logic [StateW-1:0] state_code;
    logic              make_packet;
  } node_report_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  // One row of the directed table: an item with its report, or a register write.
  typedef struct {
    row_kind_e            kind;
    wrn_item_t            item;
    logic [CfgIndexW-1:0] index;
    logic [CfgDataW-1:0]  data;
    node_report_t         want;
  } stim_row_t;

  // Indexes past the last register; writes to them must be dropped.
  localparam logic [CfgIndexW-1:0] CFG_UNMAPPED_A = 3'd6;
  localparam logic [CfgIndexW-1:0] CFG_UNMAPPED_B = 3'd7;

  localparam int unsigned SettleCycles = 4;
  localparam int unsigned PhaseCount   = 8;
  localparam int unsigned ReportLimit  = 10;

  logic clk_i;
  logic rst_ni;

  wrn_in_if  in_if ();
  wrn_out_if out_if ();
  wrn_cfg_if cfg_if ();

  wakeup_radio_node_controller DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  // Shadow copy of the node: registers and mode state.
  wrn_cfg_t            cfg_shadow;
  logic [StateW-1:0]   node_mode;
  logic                wakeup_seen;
  logic [BackoffW-1:0] backoff_left;
  logic [AirtimeW-1:0] airtime_left;
  logic [WakeupW-1:0]  wakeup_left;
  logic [TimeoutW-1:0] rx_wait_left;

  node_report_t expected_reports[$];
  stim_row_t    dir_rows[$];
  int unsigned  mismatch_count;
  int unsigned  src_gap_pct;
  int unsigned  sink_stall_pct;

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard limit on the run time.
  initial begin
    #6_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic int unsigned pick_gap();
    if ($urandom_range(99) < 85) begin
      return $urandom_range(3, 1);
    end
    return $urandom_range(40, 10);
  endfunction

  function automatic void enter_transmit();
    airtime_left = cfg_shadow.airtime_ticks;
    backoff_left = cfg_shadow.backoff_ticks;
    node_mode    = MODE_TRANSMIT;
  endfunction

  // A new or received packet goes out directly or behind a wake-up signal.
  function automatic void forward_packet();
    if (cfg_shadow.multi_hop) begin
      wakeup_left = cfg_shadow.wakeup_delay;
      node_mode   = MODE_SEND_WU;
    end else begin
      enter_transmit();
    end
  endfunction

  // Advance the shadow node by one item; returns 1 when the item yields a report.
  function automatic bit advance_node(input wrn_item_t it, output node_report_t rep);
    logic made;
    made = 1'b0;
    rep  = '0;
    if (it.operation == OP_WAKEUP) begin
      if (it.wakeup_dst == cfg_shadow.node_id) begin
        wakeup_seen = 1'b1;
      end
      return 1'b0;
    end
    case (node_mode)
      MODE_SLEEP: begin
        if (wakeup_seen) begin
          wakeup_left = cfg_shadow.wakeup_delay;
          node_mode   = MODE_RECV_WU;
        end else if (backoff_left == '0) begin
          if (it.gen_hit) begin
            made = 1'b1;
            forward_packet();
          end
        end else begin
          backoff_left = backoff_left - 1'b1;
        end
      end
      MODE_RECEIVE: begin
        if (it.packet_in_buffer) begin
          rx_wait_left = '0;
          forward_packet();
        end else if (rx_wait_left <= 1) begin
          node_mode = MODE_SLEEP;
        end else begin
          rx_wait_left = rx_wait_left - 1'b1;
        end
      end
      MODE_TRANSMIT: begin
        if (airtime_left > 1) begin
          airtime_left = airtime_left - 1'b1;
        end else begin
          node_mode = MODE_SLEEP;
        end
      end
      MODE_SEND_WU: begin
        if (wakeup_left > 1) begin
          wakeup_left = wakeup_left - 1'b1;
        end else begin
          enter_transmit();
        end
      end
      MODE_RECV_WU: begin
        if (wakeup_left <= 1) begin
          node_mode    = MODE_RECEIVE;
          wakeup_seen  = 1'b0;
          rx_wait_left = cfg_shadow.receive_timeout;
        end else begin
          wakeup_left = wakeup_left - 1'b1;
        end
      end
      // Listen and unused codes hold.
      default: ;
    endcase
    rep.state_code  = node_mode;
    rep.make_packet = made;
    return 1'b1;
  endfunction

  function automatic void store_register(input logic [CfgIndexW-1:0] idx,
                                         input logic [CfgDataW-1:0] value);
    case (idx)
      CFG_NODE_ID:         cfg_shadow.node_id         = value[NodeIdW-1:0];
      CFG_MULTI_HOP:       cfg_shadow.multi_hop       = value[0];
      CFG_AIRTIME_TICKS:   cfg_shadow.airtime_ticks   = value[AirtimeW-1:0];
      CFG_BACKOFF_TICKS:   cfg_shadow.backoff_ticks   = value[BackoffW-1:0];
      CFG_WAKEUP_DELAY:    cfg_shadow.wakeup_delay    = value[WakeupW-1:0];
      CFG_RECEIVE_TIMEOUT: cfg_shadow.receive_timeout = value[TimeoutW-1:0];
      default: ;
    endcase
  endfunction

  // Put a register value in the low bits and random junk above its width.
  function automatic logic [CfgDataW-1:0] with_junk(input int unsigned value,
                                                    input int unsigned width);
    logic [CfgDataW-1:0] keep;
    keep = (CfgDataW'(1) << width) - 1'b1;
    return (CfgDataW'($urandom) & ~keep) | (CfgDataW'(value) & keep);
  endfunction

  function automatic void add_tick(input logic gen, input logic pkt,
                                   input logic [StateW-1:0] st, input logic mk);
    stim_row_t row;
    row      = '{kind: ROW_ITEM, item: '0, index: '0, data: '0, want: '0};
    row.item = '{operation: OP_TICK, wakeup_dst: NodeIdW'($urandom), gen_hit: gen,
                 packet_in_buffer: pkt};
    row.want = '{state_code: st, make_packet: mk};
    dir_rows.push_back(row);
  endfunction

  function automatic void add_wakeup(input logic [NodeIdW-1:0] dst, input logic gen,
                                     input logic pkt);
    stim_row_t row;
    row      = '{kind: ROW_ITEM, item: '0, index: '0, data: '0, want: '0};
    row.item = '{operation: OP_WAKEUP, wakeup_dst: dst, gen_hit: gen,
                 packet_in_buffer: pkt};
    dir_rows.push_back(row);
  endfunction

  function automatic void add_cfg(input logic [CfgIndexW-1:0] idx,
                                  input logic [CfgDataW-1:0] value);
    dir_rows.push_back('{kind: ROW_CFG, item: '0, index: idx, data: value, want: '0});
  endfunction

  // Offer one item, wait for its beat, record what it should report, then maybe pause.
  task automatic send_item(input wrn_item_t it, input bit typed, input node_report_t want);
    node_report_t predicted;
    int unsigned  gap;
    in_if.valid            <= 1'b1;
    in_if.operation        <= it.operation;
    in_if.wakeup_dst       <= it.wakeup_dst;
    in_if.gen_hit          <= it.gen_hit;
    in_if.packet_in_buffer <= it.packet_in_buffer;
    do @(posedge clk_i); while (!in_if.ready);
    if (advance_node(it, predicted)) begin
      expected_reports.push_back(typed ? want : predicted);
    end
    if ($urandom_range(99) < src_gap_pct) begin
      gap = pick_gap();
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Leaves cfg valid high; the caller lowers it after the last write of a batch.
  task automatic cfg_write(input logic [CfgIndexW-1:0] idx, input logic [CfgDataW-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    store_register(idx, value);
  endtask

  // Stop sending and wait until every report is in and the pipeline is empty.
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Result side back-pressure.
  initial begin : sink_pacing
    int unsigned hold;
    out_if.ready = 1'b0;
    @(posedge clk_i);
    forever begin
      if ($urandom_range(99) < sink_stall_pct) begin
        hold = pick_gap();
        out_if.ready <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      @(posedge clk_i);
    end
  end

  // Compare every accepted report beat with the oldest expectation.
  always @(posedge clk_i) begin : report_check
    node_report_t got;
    node_report_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got = '{state_code: out_if.state_code, make_packet: out_if.make_packet};
      if (expected_reports.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= ReportLimit) begin
          $display("unexpected report beat: state_code %0d make_packet %0b",
                   got.state_code, got.make_packet);
        end
      end else begin
        want = expected_reports.pop_front();
        if (got.state_code !== want.state_code || got.make_packet !== want.make_packet) begin
          mismatch_count++;
          if (mismatch_count <= ReportLimit) begin
            $display("report mismatch: expected state_code %0d make_packet %0b, got %0d %0b",
                     want.state_code, want.make_packet, got.state_code, got.make_packet);
          end
        end
      end
    end
  end

  // Main sequence.
  initial begin : stimulus
    int unsigned v_node;
    int unsigned v_hop;
    int unsigned v_air;
    int unsigned v_backoff;
    int unsigned v_delay;
    int unsigned v_timeout;
    int unsigned n_items;
    bit          prev_cfg;
    wrn_item_t   it;

    rst_ni                 = 1'b0;
    in_if.valid            = 1'b0;
    in_if.operation        = OP_TICK;
    in_if.wakeup_dst       = '0;
    in_if.gen_hit          = 1'b0;
    in_if.packet_in_buffer = 1'b0;
    cfg_if.valid           = 1'b0;
    cfg_if.index           = CFG_NODE_ID;
    cfg_if.data            = '0;
    mismatch_count         = 0;
    src_gap_pct            = 25;
    sink_stall_pct         = 25;

    cfg_shadow = '{node_id: '0, multi_hop: 1'b0, airtime_ticks: AIRTIME_RST,
                   backoff_ticks: '0, wakeup_delay: WAKEUP_RST, receive_timeout: TIMEOUT_RST};
    node_mode    = MODE_SLEEP;
    wakeup_seen  = 1'b0;
    backoff_left = '0;
    airtime_left = '0;
    wakeup_left  = '0;
    rx_wait_left = '0;

    // Defaults after reset: node 0, direct to gateway, one-tick airtime, no backoff.
    add_tick(1'b0, 1'b1, MODE_SLEEP, 1'b0);
    add_tick(1'b1, 1'b0, MODE_TRANSMIT, 1'b1);
    add_tick(1'b1, 1'b1, MODE_SLEEP, 1'b0);
    // A wake-up for another node leaves the flag clear.
    add_wakeup(10'd1023, 1'b0, 1'b0);
    add_tick(1'b0, 1'b0, MODE_SLEEP, 1'b0);
    // Top address, multi-hop, and every delay register at zero.
    add_cfg(CFG_NODE_ID, 20'hFFFFF);
    add_cfg(CFG_MULTI_HOP, 20'h00001);
    add_cfg(CFG_AIRTIME_TICKS, 20'h00000);
    add_cfg(CFG_BACKOFF_TICKS, 20'h00000);
    add_cfg(CFG_WAKEUP_DELAY, 20'hFFF00);
    add_cfg(CFG_RECEIVE_TIMEOUT, 20'hF0000);
    add_cfg(CFG_UNMAPPED_A, 20'hFFFFF);
    add_cfg(CFG_UNMAPPED_B, 20'h5A5A5);
    // The flag wins over a packet draw; zero delays behave like one tick.
    add_wakeup(10'd1023, 1'b0, 1'b0);
    add_tick(1'b1, 1'b1, MODE_RECV_WU, 1'b0);
    add_tick(1'b1, 1'b1, MODE_RECEIVE, 1'b0);
    add_tick(1'b1, 1'b0, MODE_SLEEP, 1'b0);
    add_tick(1'b1, 1'b0, MODE_SEND_WU, 1'b1);
    // A wake-up while sending is latched and acted on back in sleep.
    add_wakeup(10'd1023, 1'b0, 1'b0);
    add_tick(1'b0, 1'b0, MODE_TRANSMIT, 1'b0);
    add_tick(1'b0, 1'b0, MODE_SLEEP, 1'b0);
    add_tick(1'b1, 1'b0, MODE_RECV_WU, 1'b0);
    add_tick(1'b0, 1'b0, MODE_RECEIVE, 1'b0);
    // A buffered packet is forwarded without a make pulse.
    add_tick(1'b0, 1'b1, MODE_SEND_WU, 1'b0);
    add_tick(1'b0, 1'b0, MODE_TRANSMIT, 1'b0);
    add_tick(1'b0, 1'b0, MODE_SLEEP, 1'b0);
    // Wake-up beats ignore the tick-only fields.
    add_wakeup(10'd0, 1'b1, 1'b1);
    add_tick(1'b0, 1'b0, MODE_SLEEP, 1'b0);
    // Backoff holds off the next packet for its full count.
    add_cfg(CFG_MULTI_HOP, 20'hFFFFE);
    add_cfg(CFG_BACKOFF_TICKS, 20'h00002);
    add_tick(1'b1, 1'b0, MODE_TRANSMIT, 1'b1);
    add_tick(1'b1, 1'b0, MODE_SLEEP, 1'b0);
    add_tick(1'b1, 1'b0, MODE_SLEEP, 1'b0);
    add_tick(1'b1, 1'b0, MODE_SLEEP, 1'b0);
    add_tick(1'b1, 1'b0, MODE_TRANSMIT, 1'b1);
    add_tick(1'b0, 1'b0, MODE_SLEEP, 1'b0);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed table.
    prev_cfg = 1'b0;
    foreach (dir_rows[r]) begin
      if (dir_rows[r].kind == ROW_CFG) begin
        if (!prev_cfg) begin
          wait_drained();
        end
        cfg_write(dir_rows[r].index, dir_rows[r].data);
        prev_cfg = 1'b1;
      end else begin
        if (prev_cfg) begin
          cfg_if.valid <= 1'b0;
        end
        send_item(dir_rows[r].item, 1'b1, dir_rows[r].want);
        prev_cfg = 1'b0;
      end
    end

    // Random phases, each under its own register setting.
    for (int p = 0; p < PhaseCount; p++) begin
      wait_drained();
      if (p == 0) begin
        v_node    = 1023;
        v_hop     = 1;
        v_air     = 65535;
        v_backoff = 1048575;
        v_delay   = 255;
        v_timeout = 65535;
      end else if (p == PhaseCount - 1) begin
        v_node    = 0;
        v_hop     = 0;
        v_air     = 1;
        v_backoff = 0;
        v_delay   = 1;
        v_timeout = 1;
      end else begin
        // Short delays so that the whole mode cycle turns over many times.
        v_node    = $urandom_range(1023);
        v_hop     = $urandom_range(1);
        v_air     = ($urandom_range(9) == 0) ? 0 : $urandom_range(12, 1);
        v_backoff = $urandom_range(20);
        v_delay   = ($urandom_range(9) == 0) ? 0 : $urandom_range(10, 1);
        v_timeout = ($urandom_range(9) == 0) ? 0 : $urandom_range(25, 1);
      end
      cfg_write(CFG_NODE_ID, with_junk(v_node, NodeIdW));
      cfg_write(CFG_MULTI_HOP, with_junk(v_hop, 1));
      cfg_write(CFG_AIRTIME_TICKS, with_junk(v_air, AirtimeW));
      cfg_write(CFG_BACKOFF_TICKS, with_junk(v_backoff, BackoffW));
      cfg_write(CFG_WAKEUP_DELAY, with_junk(v_delay, WakeupW));
      cfg_write(CFG_RECEIVE_TIMEOUT, with_junk(v_timeout, TimeoutW));
      cfg_write($urandom_range(1) ? CFG_UNMAPPED_A : CFG_UNMAPPED_B, CfgDataW'($urandom));
      cfg_if.valid <= 1'b0;

      // Every third phase runs without any idling on either side.
      src_gap_pct    = (p % 3 == 1) ? 0 : $urandom_range(50, 10);
      sink_stall_pct = (p % 3 == 1) ? 0 : $urandom_range(50, 10);
      n_items        = (p == 0) ? 80 : 160;

      for (int k = 0; k < n_items; k++) begin
        // Halfway through, let the block empty out completely.
        if (k == n_items / 2) begin
          wait_drained();
        end
        it.operation        = ($urandom_range(99) < 15) ? OP_WAKEUP : OP_TICK;
        it.wakeup_dst       = ($urandom_range(99) < 70) ? cfg_shadow.node_id
                                                        : NodeIdW'($urandom);
        it.gen_hit          = ($urandom_range(99) < 40);
        it.packet_in_buffer = ($urandom_range(99) < 25);
        send_item(it, 1'b0, '0);
      end
    end

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0 && expected_reports.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
